>>> rtl/core/qts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_pkg
// Shared sizes, codes and types for the two-stack queue.
// ----------------------------------------------------------------------------
package qts_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DATA_W      = 32;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POUR_RD,
		S_POUR_WR,
		S_FINISH,
		S_RESULT
	} state_t;

endpackage

>>> rtl/core/qts_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_ifs
// Valid/ready channels for request and response words of the queue.
// ----------------------------------------------------------------------------
interface qts_req_if
	import qts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] data_in;

	modport source (output valid, output operation, output data_in, input ready);
	modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface qts_rsp_if
	import qts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic [1:0]               status;

	modport source (output valid, output data_out, output status, input ready);
	modport sink   (input valid, input data_out, input status, output ready);
endinterface

>>> rtl/core/qts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_ram
// Single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module qts_ram #(
	parameter int AW = 4,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/queue_from_two_stacks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// First-in first-out queue built from an input stack and an output stack.
// ----------------------------------------------------------------------------
// A request word carries an operation (enqueue or dequeue) and the data to
// enqueue. Every request gives exactly one response word with the dequeued
// data and a status: ok, rejected because full, or dequeue on an empty queue.
// Requests are taken one at a time; ready is low while a request is in work.
// A request that needs no pour goes from acceptance through the finish and
// result states into the response register, and the next request can be
// taken once the block is back in idle. When a dequeue finds the output stack
// empty, or an enqueue finds the input stack full and the output stack empty,
// the input stack is poured into the output stack entry by entry (a read of
// the input stack memory, then a write into the output stack memory).
// Each entry is poured once.
// The response sits in an output register; the next request is accepted while
// it waits, and its result is held back until the receiver takes the old one.
// Reset empties both stacks at once; no clearing pass is needed since only
// entries below a stack's count are ever read.
// ----------------------------------------------------------------------------
module queue_from_two_stacks
	import qts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	qts_req_if.sink  req,
	qts_rsp_if.source rsp
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  ic_q, ic_d;
	logic [CNT_W-1:0]  oc_q, oc_d;
	op_t               op_q;
	logic [DATA_W-1:0] data_q;
	status_t           res_status_q, res_status_d;
	logic              use_ram_q, use_ram_d;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_data_q;
	status_t           rsp_status_q;

	logic              in_we, in_re, out_we, out_re;
	logic [ADDR_W-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
	logic [DATA_W-1:0] in_rdata, out_rdata;
	logic [CNT_W-1:0]  ic_m1, oc_m1;
	logic              accept, load_rsp;

	assign ic_m1  = ic_q - CNT_W'(1);
	assign oc_m1  = oc_q - CNT_W'(1);
	assign accept = req.valid && req.ready;

	qts_ram #(.AW(ADDR_W), .DW(DATA_W)) u_in_stack (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (data_q),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	qts_ram #(.AW(ADDR_W), .DW(DATA_W)) u_out_stack (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (in_rdata),
		.re    (out_re),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	assign in_waddr  = ic_q[ADDR_W-1:0];
	assign in_raddr  = ic_m1[ADDR_W-1:0];
	assign out_waddr = oc_q[ADDR_W-1:0];
	assign out_raddr = oc_m1[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ic_q         <= '0;
			oc_q         <= '0;
			res_status_q <= ST_OK;
			use_ram_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			ic_q         <= ic_d;
			oc_q         <= oc_d;
			res_status_q <= res_status_d;
			use_ram_q    <= use_ram_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(req.operation);
			data_q <= req.data_in;
		end
		if (load_rsp) begin
			rsp_data_q   <= use_ram_q ? out_rdata : '0;
			rsp_status_q <= res_status_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		ic_d         = ic_q;
		oc_d         = oc_q;
		res_status_d = res_status_q;
		use_ram_d    = use_ram_q;
		req.ready    = 1'b0;
		in_we        = 1'b0;
		in_re        = 1'b0;
		out_we       = 1'b0;
		out_re       = 1'b0;
		load_rsp     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (op_t'(req.operation) == OP_ENQ) begin
						state_d = (ic_q == DEPTH_CNT && oc_q == '0) ? S_POUR_RD : S_FINISH;
					end else begin
						state_d = (oc_q == '0 && ic_q != '0) ? S_POUR_RD : S_FINISH;
					end
				end
			end
			S_POUR_RD: begin
				in_re   = 1'b1;
				ic_d    = ic_m1;
				state_d = S_POUR_WR;
			end
			S_POUR_WR: begin
				out_we  = 1'b1;
				oc_d    = oc_q + CNT_W'(1);
				state_d = (ic_q != '0 && oc_d < DEPTH_CNT) ? S_POUR_RD : S_FINISH;
			end
			S_FINISH: begin
				use_ram_d = 1'b0;
				state_d   = S_RESULT;
				if (op_q == OP_ENQ) begin
					if (ic_q < DEPTH_CNT) begin
						in_we        = 1'b1;
						ic_d         = ic_q + CNT_W'(1);
						res_status_d = ST_OK;
					end else begin
						res_status_d = ST_FULL;
					end
				end else begin
					if (oc_q == '0) begin
						res_status_d = ST_EMPTY;
					end else begin
						out_re       = 1'b1;
						oc_d         = oc_m1;
						use_ram_d    = 1'b1;
						res_status_d = ST_OK;
					end
				end
			end
			S_RESULT: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.data_out = rsp_data_q;
	assign rsp.status   = rsp_status_q;

	a_counts_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ic_q <= DEPTH_CNT && oc_q <= DEPTH_CNT)
		else $error("stack count beyond depth");

	a_pour_moves_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POUR_WR |=> oc_q == $past(oc_q) + CNT_W'(1))
		else $error("pour write did not advance the output count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while another is in work");

	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESULT))
		else $error("response raised outside the result state");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO built from an input and an output stack.
// ----------------------------------------------------------------------------
// A short table of directed words covers the empty queue, the data extremes,
// a dequeue that refills an empty output stack, a full input stack and
// a rejected enqueue. Random words follow in segments that lean to enqueues,
// to dequeues or to a mix, so that full, empty and both kinds of pour come up
// again and again. The request side sends in bursts with random gaps and now
// and then waits for the queue to drain. The response side stalls on modes of
// its own. Each response word is checked against its table row if that row is
// typed, else against a cycle-free model of the two stacks kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
	import qts_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           status;
	} queue_result_t;

	typedef struct {
		op_t               op;
		logic [DATA_W-1:0] data;
		bit                typed;
		queue_result_t     want;
	} stim_row_t;

	typedef enum int {
		MIX_BALANCED,
		MIX_MOSTLY_ENQ,
		MIX_MOSTLY_DEQ,
		MIX_FILL,
		MIX_DRAIN
	} op_mix_t;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN,
		RX_LONG_STALLS
	} rx_mode_t;

	localparam int RANDOM_WORDS = 1050;
	localparam int MAX_GAP      = 8;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 60;

	logic clk;
	logic arst_n;

	qts_req_if req ();
	qts_rsp_if rsp ();

	queue_from_two_stacks i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	logic [DATA_W-1:0] in_stack  [STACK_DEPTH];
	logic [DATA_W-1:0] out_stack [STACK_DEPTH];
	int                in_count;
	int                out_count;

	queue_result_t pending_results [$];
	stim_row_t     directed_rows [$];

	int mismatches;
	int n_checked;
	int n_enq;
	int n_deq;
	int n_full;
	int n_empty;
	int n_enq_pours;
	int n_deq_pours;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d responses still expected.", pending_results.size());
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic void pour_stacks();
		while (in_count > 0 && out_count < STACK_DEPTH) begin
			in_count--;
			out_stack[out_count] = in_stack[in_count];
			out_count++;
		end
	endfunction

	function automatic queue_result_t predict_queue_result(op_t op, logic [DATA_W-1:0] value);
		queue_result_t res;
		res.data   = '0;
		res.status = ST_OK;
		if (op == OP_ENQ) begin
			n_enq++;
			if (in_count >= STACK_DEPTH) begin
				if (out_count == 0) begin
					pour_stacks();
					n_enq_pours++;
				end else begin
					res.status = ST_FULL;
					n_full++;
				end
			end
			if (res.status == ST_OK && in_count < STACK_DEPTH) begin
				in_stack[in_count] = value;
				in_count++;
			end
		end else begin
			n_deq++;
			if (out_count == 0 && in_count != 0) begin
				pour_stacks();
				n_deq_pours++;
			end
			if (out_count == 0) begin
				res.status = ST_EMPTY;
				n_empty++;
			end else begin
				out_count--;
				res.data = out_stack[out_count];
			end
		end
		return res;
	endfunction

	task automatic add_row(op_t op, logic [DATA_W-1:0] data, bit typed,
			logic [DATA_W-1:0] exp_data, status_t exp_status);
		stim_row_t row;
		row.op          = op;
		row.data        = data;
		row.typed       = typed;
		row.want.data   = exp_data;
		row.want.status = exp_status;
		directed_rows.push_back(row);
	endtask

	task automatic drive_word(op_t op, logic [DATA_W-1:0] value, bit typed,
			queue_result_t want);
		queue_result_t predicted;
		req.valid     <= 1'b1;
		req.operation <= op;
		req.data_in   <= value;
		do @(posedge clk); while (!req.ready);
		predicted = predict_queue_result(op, value);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("response word %h/%0d with no request waiting",
					rsp.data_out, rsp.status));
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (rsp.data_out !== want.data)
					report_mismatch($sformatf("data_out %h, expected %h",
						rsp.data_out, want.data));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
			end
		end
	end

	initial begin
		rx_mode_t    mode;
		int          mode_left;
		int          hold;
		logic [15:0] pattern;
		mode_left = 0;
		hold      = 0;
		pattern   = 16'b1011_0011_1000_1110;
		mode      = RX_ALWAYS;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				RX_ALWAYS: begin
					rsp.ready <= 1'b1;
				end
				RX_RANDOM: begin
					rsp.ready <= ($urandom_range(0, 9) < 7);
				end
				RX_PATTERN: begin
					rsp.ready <= pattern[0];
					pattern = {pattern[0], pattern[15:1]};
				end
				default: begin
					if (hold > 0) begin
						rsp.ready <= 1'b0;
						hold--;
					end else begin
						rsp.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							hold = $urandom_range(5, 20);
					end
				end
			endcase
		end
	end

	initial begin
		int                burst_left;
		int                gap;
		int                seg_left;
		bit                drain;
		op_mix_t           mix;
		op_t               op;
		logic [DATA_W-1:0] value;

		burst_left    = 0;
		seg_left      = 0;
		mix           = MIX_BALANCED;
		in_count      = 0;
		out_count     = 0;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_ENQ;
		req.data_in   = '0;

		// The oldest word sits at the bottom of the input stack, so it comes out first.
		add_row(OP_DEQ, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_EMPTY);
		add_row(OP_ENQ, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK);
		add_row(OP_ENQ, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK);
		add_row(OP_DEQ, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK);
		for (int i = 0; i < STACK_DEPTH; i++)
			add_row(OP_ENQ, (i % 2) ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i)),
				1'b1, 32'h0000_0000, ST_OK);
		add_row(OP_ENQ, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_FULL);
		add_row(OP_DEQ, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK);
		add_row(OP_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK);
		add_row(OP_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i])
			drive_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
				directed_rows[i].want);

		req.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (seg_left == 0) begin
				mix      = op_mix_t'($urandom_range(0, 4));
				seg_left = $urandom_range(10, 60);
			end
			seg_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
				drain      = ($urandom_range(0, 39) == 0);
				if (drain && gap == 0)
					gap = 1;
				if (gap != 0) begin
					req.valid <= 1'b0;
					repeat (gap) @(negedge clk);
					while (drain && pending_results.size() != 0) @(negedge clk);
				end
			end
			burst_left--;
			case (mix)
				MIX_MOSTLY_ENQ: op = ($urandom_range(0, 99) < 85) ? OP_ENQ : OP_DEQ;
				MIX_MOSTLY_DEQ: op = ($urandom_range(0, 99) < 85) ? OP_DEQ : OP_ENQ;
				MIX_FILL:       op = OP_ENQ;
				MIX_DRAIN:      op = OP_DEQ;
				default:        op = op_t'($urandom_range(0, 1));
			endcase
			case ($urandom_range(0, 15))
				0:       value = 32'h0000_0000;
				1:       value = 32'hFFFF_FFFF;
				2:       value = 32'h7FFF_FFFF;
				3:       value = 32'h8000_0000;
				default: value = $urandom;
			endcase
			drive_word(op, value, 1'b0, '0);
		end
		req.valid <= 1'b0;

		for (int c = 0; c < DRAIN_LIMIT && pending_results.size() != 0; c++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected responses never arrived",
				pending_results.size()));

		$display("Checked %0d responses: %0d enqueues (%0d rejected as full), %0d dequeues (%0d on an empty queue).",
			n_checked, n_enq, n_full, n_deq, n_empty);
		$display("Stack pours: %0d on enqueue, %0d on dequeue; %0d mismatches.",
			n_enq_pours, n_deq_pours, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
